// File: src/e2q_pkg.sv
// Shared constants, types and the CORDIC angle table for the Euler to quaternion block.
// No dependencies.
package e2q_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned TrigW       = 32;   // Q2.30 sine/cosine
  localparam int unsigned AngW        = 26;   // 1/65536 degree, folded to +-90 degrees
  localparam int unsigned ProdW       = 64;
  localparam int unsigned SumW        = 34;

  localparam logic signed [16:0] HalfRight = 17'sd23040;
  localparam logic signed [16:0] HalfTurn  = 17'sd46080;
  localparam logic signed [TrigW-1:0] CordicGain = 32'sd652032874;

  typedef logic signed [TrigW-1:0] trig_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } sincos_t;

  function automatic logic signed [AngW-1:0] atan_deg(input logic [3:0] idx);
    logic signed [AngW-1:0] r;
    begin
      case (idx)
        4'd0:  r = 26'sd2949120;
        4'd1:  r = 26'sd1740967;
        4'd2:  r = 26'sd919879;
        4'd3:  r = 26'sd466945;
        4'd4:  r = 26'sd234379;
        4'd5:  r = 26'sd117304;
        4'd6:  r = 26'sd58666;
        4'd7:  r = 26'sd29335;
        4'd8:  r = 26'sd14668;
        4'd9:  r = 26'sd7334;
        4'd10: r = 26'sd3667;
        4'd11: r = 26'sd1833;
        4'd12: r = 26'sd917;
        4'd13: r = 26'sd458;
        4'd14: r = 26'sd229;
        4'd15: r = 26'sd115;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: src/euler_to_quaternion.sv
// Channel | dir | signals                                 | width
// in      | in  | valid_i, ready_o, roll/pitch/yaw_deg_i   | 3 x 16 signed, 1/128 degree
// out     | out | valid_o, ready_i, quat_w/x/y/z_o        | 4 x 16 signed Q1.15
// One beat per cycle unless the output stalls; 17 CORDIC stages, 4 product stages.
// The whole pipeline advances together whenever the output stage is empty or taken.
// A stall freezes every stage; no beat is lost or repeated.
// Reset clears only the valid bits.
// Top level: three CORDIC pipes and the product pipe; depends on e2q_pkg.
module euler_to_quaternion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [15:0] roll_deg_i,
  input  logic signed [15:0] pitch_deg_i,
  input  logic signed [15:0] yaw_deg_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] quat_x_o,
  output logic signed [15:0] quat_y_o,
  output logic signed [15:0] quat_z_o
);

  localparam int unsigned Depth = e2q_pkg::CordicSteps + 5;

  logic [Depth-1:0] vld_q;
  logic             en;

  assign en      = ready_i || !vld_q[Depth-1];
  assign ready_o = en;
  assign valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  e2q_pkg::sincos_t sc_r, sc_p, sc_y;

  e2q_cordic u_roll  (.clk_i, .en_i(en), .half_i(roll_deg_i),  .sc_o(sc_r));
  e2q_cordic u_pitch (.clk_i, .en_i(en), .half_i(pitch_deg_i), .sc_o(sc_p));
  e2q_cordic u_yaw   (.clk_i, .en_i(en), .half_i(yaw_deg_i),   .sc_o(sc_y));

  e2q_products u_prod (
    .clk_i, .en_i(en), .r_i(sc_r), .p_i(sc_p), .y_i(sc_y),
    .quat_w_o, .quat_x_o, .quat_y_o, .quat_z_o
  );

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(quat_w_o) && $stable(quat_z_o))
    else $error("output beat changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o) else $error("pipeline stalled while output empty");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ready_i && !vld_q[Depth-2] |=> !valid_o)
    else $error("beat invented at output");

endmodule

// File: src/e2q_cordic.sv
// Pipelined rotation-mode CORDIC: half angle in 1/256 degree to Q2.30 cosine and sine.
// Depends on e2q_pkg. One stage per iteration, advanced by en_i.
module e2q_cordic (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [15:0]    half_i,
  output e2q_pkg::sincos_t      sc_o
);

  localparam int unsigned N = e2q_pkg::CordicSteps;

  e2q_pkg::trig_t                    x_q [N+1];
  e2q_pkg::trig_t                    y_q [N+1];
  logic signed [e2q_pkg::AngW-1:0]   z_q [N+1];
  logic                              flip_q [N+1];

  // fold beyond +-90 degrees by half a turn, negating the result at the end
  logic signed [16:0] h_ext, h_fold;
  logic               flip_d;
  always_comb begin
    h_ext  = {half_i[15], half_i};
    h_fold = h_ext;
    flip_d = 1'b0;
    if (h_ext > e2q_pkg::HalfRight) begin
      h_fold = h_ext - e2q_pkg::HalfTurn;
      flip_d = 1'b1;
    end else if (h_ext < -e2q_pkg::HalfRight) begin
      h_fold = h_ext + e2q_pkg::HalfTurn;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= e2q_pkg::CordicGain;
      y_q[0]    <= '0;
      z_q[0]    <= {{(e2q_pkg::AngW-25){h_fold[16]}}, h_fold, 8'd0};
      flip_q[0] <= flip_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    e2q_pkg::trig_t dx, dy;
    assign dx = x_q[i] >>> 0;
    assign dy = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][e2q_pkg::AngW-1]) begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + (dx >>> i);
          z_q[i+1] <= z_q[i] - e2q_pkg::atan_deg(4'(i));
        end else begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - (dx >>> i);
          z_q[i+1] <= z_q[i] + e2q_pkg::atan_deg(4'(i));
        end
      end
    end
  end

  assign sc_o.c = flip_q[N] ? -x_q[N] : x_q[N];
  assign sc_o.s = flip_q[N] ? -y_q[N] : y_q[N];

endmodule

// File: src/e2q_products.sv
// Pipelined ZYX quaternion products: two multiply stages, sum and Q1.15 rounding.
// Depends on e2q_pkg. Advanced by en_i.
module e2q_products (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  e2q_pkg::sincos_t     r_i,
  input  e2q_pkg::sincos_t     p_i,
  input  e2q_pkg::sincos_t     y_i,
  output logic signed [15:0]   quat_w_o,
  output logic signed [15:0]   quat_x_o,
  output logic signed [15:0]   quat_y_o,
  output logic signed [15:0]   quat_z_o
);

  localparam int unsigned PW = e2q_pkg::ProdW;
  localparam int unsigned TW = e2q_pkg::TrigW;
  localparam int unsigned SW = e2q_pkg::SumW;

  // pair products cr*cp, sr*sp, sr*cp, cr*sp; yaw terms carried along
  logic signed [PW-1:0] m1 [4];
  e2q_pkg::trig_t ab_q [4];
  e2q_pkg::trig_t cy_q, sy_q;

  assign m1[0] = PW'(r_i.c) * PW'(p_i.c);
  assign m1[1] = PW'(r_i.s) * PW'(p_i.s);
  assign m1[2] = PW'(r_i.s) * PW'(p_i.c);
  assign m1[3] = PW'(r_i.c) * PW'(p_i.s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) ab_q[k] <= TW'(m1[k] >>> 30);
      cy_q <= y_i.c;
      sy_q <= y_i.s;
    end
  end

  // triple products, order: ccc, sss, scc, css, csc, scs, ccs, ssc
  logic signed [PW-1:0] m2 [8];
  e2q_pkg::trig_t t_q [8];
  assign m2[0] = PW'(ab_q[0]) * PW'(cy_q);
  assign m2[1] = PW'(ab_q[1]) * PW'(sy_q);
  assign m2[2] = PW'(ab_q[2]) * PW'(cy_q);
  assign m2[3] = PW'(ab_q[3]) * PW'(sy_q);
  assign m2[4] = PW'(ab_q[3]) * PW'(cy_q);
  assign m2[5] = PW'(ab_q[2]) * PW'(sy_q);
  assign m2[6] = PW'(ab_q[0]) * PW'(sy_q);
  assign m2[7] = PW'(ab_q[1]) * PW'(cy_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 8; k++) t_q[k] <= TW'(m2[k] >>> 30);
    end
  end

  logic signed [SW-1:0] s_q [4];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0] <= SW'(t_q[0]) + SW'(t_q[1]);
      s_q[1] <= SW'(t_q[2]) - SW'(t_q[3]);
      s_q[2] <= SW'(t_q[4]) + SW'(t_q[5]);
      s_q[3] <= SW'(t_q[6]) - SW'(t_q[7]);
    end
  end

  function automatic logic signed [15:0] to_q15(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    begin
      r = (v + SW'(1 << 14)) >>> 15;
      if (r > SW'(32767)) return 16'sh7fff;
      if (r < -SW'(32768)) return 16'sh8000;
      return r[15:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quat_w_o <= to_q15(s_q[0]);
      quat_x_o <= to_q15(s_q[1]);
      quat_y_o <= to_q15(s_q[2]);
      quat_z_o <= to_q15(s_q[3]);
    end
  end

endmodule

// File: tb/euler_to_quaternion_chk.sv
`timescale 1ns / 1ps
// Checker for the Euler to quaternion block: watches both channels, predicts each
// quaternion from the accepted angle triple and compares field by field.
// Depends on nothing but the port list of the block.
module euler_to_quaternion_chk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               ready_o,
  input  logic signed [15:0] roll_deg_i,
  input  logic signed [15:0] pitch_deg_i,
  input  logic signed [15:0] yaw_deg_i,
  input  logic               valid_o,
  input  logic               ready_i,
  input  logic signed [15:0] quat_w_o,
  input  logic signed [15:0] quat_x_o,
  input  logic signed [15:0] quat_y_o,
  input  logic signed [15:0] quat_z_o,
  output int                 fail_cnt_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  localparam longint AngRight = 23040;
  localparam longint AngTurn  = 46080;
  localparam longint GainQ30  = 652032874;

  quat_t quat_q[$];
  int    fail_cnt;
  int    pend;

  function automatic longint floor_sr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint atan_step(int i);
    case (i)
      0: return 2949120;  1: return 1740967;  2: return 919879;  3: return 466945;
      4: return 234379;   5: return 117304;   6: return 58666;   7: return 29335;
      8: return 14668;    9: return 7334;     10: return 3667;   11: return 1833;
      12: return 917;     13: return 458;     14: return 229;    default: return 115;
    endcase
  endfunction

  // Half angle in 1/256 degree; fold by a half turn and negate both terms.
  task automatic half_trig(input longint half, output longint c, output longint s);
    longint xv, yv, zv, dx, dy;
    bit     flip;
    flip = 0;
    xv = GainQ30;
    yv = 0;
    if (half > AngRight) begin
      half -= AngTurn;
      flip = 1;
    end else if (half < -AngRight) begin
      half += AngTurn;
      flip = 1;
    end
    zv = half * 256;
    for (int i = 0; i < 16; i++) begin
      dx = floor_sr(yv, i);
      dy = floor_sr(xv, i);
      if (zv >= 0) begin
        xv -= dx; yv += dy; zv -= atan_step(i);
      end else begin
        xv += dx; yv -= dy; zv += atan_step(i);
      end
    end
    c = flip ? -xv : xv;
    s = flip ? -yv : yv;
  endtask

  function automatic longint prod3(longint a, longint b, longint c);
    return floor_sr(floor_sr(a * b, 30) * c, 30);
  endfunction

  function automatic logic signed [15:0] round_q15(longint v);
    longint r;
    r = floor_sr(v + (64'sd1 <<< 14), 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic predict_quat(input logic signed [15:0] r, p, yw);
    longint cr, sr, cp, sp, cy, sy;
    quat_t  q;
    half_trig(r, cr, sr);
    half_trig(p, cp, sp);
    half_trig(yw, cy, sy);
    q.w = round_q15(prod3(cr, cp, cy) + prod3(sr, sp, sy));
    q.x = round_q15(prod3(sr, cp, cy) - prod3(cr, sp, sy));
    q.y = round_q15(prod3(cr, sp, cy) + prod3(sr, cp, sy));
    q.z = round_q15(prod3(cr, cp, sy) - prod3(sr, sp, cy));
    quat_q.push_back(q);
  endtask

  initial fail_cnt = 0;
  initial pend = 0;
  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pend;

  always @(posedge clk_i) begin
    quat_t exp_q;
    if (rst_ni) begin
      if (valid_i && ready_o) predict_quat(roll_deg_i, pitch_deg_i, yaw_deg_i);
      if (valid_o && ready_i) begin
        if (quat_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected beat w=%0d x=%0d y=%0d z=%0d",
                                       quat_w_o, quat_x_o, quat_y_o, quat_z_o);
        end else begin
          exp_q = quat_q.pop_front();
          if (exp_q.w !== quat_w_o || exp_q.x !== quat_x_o ||
              exp_q.y !== quat_y_o || exp_q.z !== quat_z_o) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                       exp_q.w, exp_q.x, exp_q.y, exp_q.z,
                       quat_w_o, quat_x_o, quat_y_o, quat_z_o);
          end
        end
      end
      pend = quat_q.size();
    end
  end

endmodule

// File: tb/euler_to_quaternion_tb.sv
`timescale 1ns / 1ps
// Top of the Euler to quaternion testbench: clock, reset, angle stimulus and verdict.
// Depends on euler_to_quaternion and euler_to_quaternion_chk.
module euler_to_quaternion_tb;

  localparam int RandBeats = 1200;
  localparam int StallLimit = 2000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [15:0] roll = 0, pitch = 0, yaw = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [15:0] qw, qx, qy, qz;
  int                 fail_cnt, pending;
  bit                 calm = 0;
  int                 idle_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  euler_to_quaternion dut (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(in_valid), .ready_o(in_ready),
    .roll_deg_i(roll), .pitch_deg_i(pitch), .yaw_deg_i(yaw),
    .valid_o(out_valid), .ready_i(out_ready),
    .quat_w_o(qw), .quat_x_o(qx), .quat_y_o(qy), .quat_z_o(qz)
  );

  euler_to_quaternion_chk chk (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(in_valid), .ready_o(in_ready),
    .roll_deg_i(roll), .pitch_deg_i(pitch), .yaw_deg_i(yaw),
    .valid_o(out_valid), .ready_i(out_ready),
    .quat_w_o(qw), .quat_x_o(qx), .quat_y_o(qy), .quat_z_o(qz),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // Receiver: ready stalls in bursts, none in the calm tail.
  always @(posedge clk) begin
    int burst;
    if (!calm && $urandom_range(0, 9) == 0) begin
      burst = $urandom_range(1, 13);
      out_ready <= 0;
      repeat (burst) @(posedge clk);
    end
    out_ready <= 1;
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);                   // any raw value, beyond nominal too
      1:       return 16'($signed($urandom_range(0, 8)) * 5760 - 23040);  // 45 degree steps
      2:       return $urandom_range(0, 1) ? 16'sd23040 : -16'sd23040;
      default: return 16'($signed($urandom_range(0, 46080)) - 23040);
    endcase
  endfunction

  task automatic send_beat(input logic signed [15:0] r, p, yw);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    roll <= r;
    pitch <= p;
    yaw <= yw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] corner [8];
    corner = '{16'sd0, 16'sd23040, -16'sd23040, 16'sh7fff, -16'sh8000, 16'sd1, -16'sd1,
               16'sd11520};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 8; i++) send_beat(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
    send_beat(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_beat(-16'sh8000, -16'sh8000, -16'sh8000);
    send_beat(16'sd23041, -16'sd23041, 16'sd0);
    send_beat(16'sh5555, 16'shaaaa, 16'sh5555);
    send_beat(16'shaaaa, 16'sh5555, 16'shaaaa);
    // Hold the sender until the pipeline has drained.
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < RandBeats; i++) begin
      if (i == RandBeats - 200) calm = 1;
      send_beat(pick_angle(), pick_angle(), pick_angle());
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/e2q_pkg.sv
src/e2q_cordic.sv
src/e2q_products.sv
src/euler_to_quaternion.sv
tb/euler_to_quaternion_chk.sv
tb/euler_to_quaternion_tb.sv
